// ----- rtl/midi_track_event_parser_defines.svh -----
// assertion macros for the midi track event parser
// expects signals named clock and reset in the module that uses them
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// property that must hold in the same cycle
`define MTEP_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MTEP_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mtep_pkg.sv -----
// shared types and codes for the midi track event parser
// no dependencies
`timescale 1ns / 1ps

package mtep_pkg;

   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_META_HEADER = 2'd1;
   localparam logic [1:0] KIND_META_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic ERR_TOO_LONG = 1'b0;
   localparam logic ERR_LENGTH_OVERFLOW = 1'b1;

   localparam logic [28:0] META_LIMIT_RESET = 29'h1000_0000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] abs_time;
      logic [3:0]  event_type;
      logic [3:0]  channel;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [7:0]  meta_type;
      logic [27:0] meta_length;
      logic [7:0]  payload_byte;
      logic        last_of_meta;
      logic        error_code;
   } result_type;

endpackage

// ----- rtl/midi_track_event_parser.sv -----
// midi track event parser: one track byte per transaction, one result at most
// depends on mtep_pkg and midi_track_event_parser_defines.svh
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_data_byte, req_restart
//   rsp      out        rsp_valid/rsp_stall   rsp_kind .. rsp_error_code
//   csr      in/out     psel/penable/pready   paddr, pwdata, prdata (meta_length_limit)
//
// one byte is taken every cycle unless req is stalled; its result is registered in the
// output register for the next cycle, set by the single parser state update and the 32-bit time add.
// reset is synchronous and returns the parser to the delta-time phase with time 0.
// a byte is accepted while the output register is empty or its result is taken
// in the same cycle, so a stall on rsp stalls req by the same cycle only.
`timescale 1ns / 1ps
`include "midi_track_event_parser_defines.svh"

module midi_track_event_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_abs_time,
   output logic [3:0]  rsp_event_type,
   output logic [3:0]  rsp_channel,
   output logic [7:0]  rsp_first_data,
   output logic [7:0]  rsp_second_data,
   output logic [7:0]  rsp_meta_type,
   output logic [27:0] rsp_meta_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_meta,
   output logic        rsp_error_code,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mtep_pkg::*;

   localparam logic [1:0] CSR_META_LENGTH_LIMIT = 2'd0;

   localparam logic [2:0] PH_DELTA = 3'd0;
   localparam logic [2:0] PH_STATUS = 3'd1;
   localparam logic [2:0] PH_DATA1 = 3'd2;
   localparam logic [2:0] PH_DATA2 = 3'd3;
   localparam logic [2:0] PH_MTYPE = 3'd4;
   localparam logic [2:0] PH_MLEN = 3'd5;
   localparam logic [2:0] PH_PAYLOAD = 3'd6;
   localparam logic [2:0] PH_ERROR = 3'd7;

   logic [28:0] limit_ff, limit_in;
   logic [2:0]  phase_ff, phase_in;
   logic [27:0] vlq_value_ff, vlq_value_in;
   logic [2:0]  vlq_count_ff, vlq_count_in;
   logic [31:0] prev_time_ff, prev_time_in;
   logic [31:0] event_time_ff, event_time_in;
   logic [3:0]  held_type_ff, held_type_in;
   logic [3:0]  held_channel_ff, held_channel_in;
   logic [7:0]  held_first_ff, held_first_in;
   logic [7:0]  held_meta_type_ff, held_meta_type_in;
   logic [27:0] meta_remaining_ff, meta_remaining_in;
   logic [27:0] meta_total_ff, meta_total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  result_ff, result_in;

   logic        accept;
   logic        emit;
   logic [27:0] vlq_shift;
   logic [2:0]  vlq_count_inc;
   logic        vlq_done;
   logic        vlq_long;
   logic [31:0] delta_sum;
   logic [27:0] remaining_dec;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;

   // csr: single register at address 0
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_META_LENGTH_LIMIT) ? {3'b000, limit_ff} : 32'd0;
   assign limit_in = (psel && penable && pwrite && (paddr == CSR_META_LENGTH_LIMIT)) ?
                     pwdata[28:0] : limit_ff;

   assign vlq_shift = {vlq_value_ff[20:0], req_data_byte[6:0]};
   assign vlq_count_inc = vlq_count_ff + 3'd1;
   assign vlq_done = !req_data_byte[7];
   assign vlq_long = req_data_byte[7] && (vlq_count_inc >= 3'd4);
   assign delta_sum = prev_time_ff + {4'b0000, vlq_shift};
   assign remaining_dec = meta_remaining_ff - 28'd1;

   always_comb begin
      phase_in = phase_ff;
      vlq_value_in = vlq_value_ff;
      vlq_count_in = vlq_count_ff;
      prev_time_in = prev_time_ff;
      event_time_in = event_time_ff;
      held_type_in = held_type_ff;
      held_channel_in = held_channel_ff;
      held_first_in = held_first_ff;
      held_meta_type_in = held_meta_type_ff;
      meta_remaining_in = meta_remaining_ff;
      meta_total_in = meta_total_ff;
      result_in = '0;
      emit = 1'b0;

      if (req_restart) begin
         phase_in = PH_DELTA;
         vlq_value_in = '0;
         vlq_count_in = '0;
         prev_time_in = '0;
         event_time_in = '0;
         held_type_in = '0;
         held_channel_in = '0;
         held_first_in = '0;
         held_meta_type_in = '0;
         meta_remaining_in = '0;
         meta_total_in = '0;
      end else begin
         unique case (phase_ff)
            PH_DELTA: begin
               vlq_value_in = vlq_shift;
               vlq_count_in = vlq_count_inc;
               if (vlq_done) begin
                  event_time_in = delta_sum;
                  prev_time_in = delta_sum;
                  vlq_value_in = '0;
                  vlq_count_in = '0;
                  phase_in = PH_STATUS;
               end else if (vlq_long) begin
                  emit = 1'b1;
                  result_in.kind = KIND_ERROR;
                  result_in.abs_time = prev_time_ff;
                  result_in.error_code = ERR_TOO_LONG;
                  phase_in = PH_ERROR;
               end
            end
            PH_STATUS: begin
               if (req_data_byte == 8'hFF) begin
                  phase_in = PH_MTYPE;
               end else begin
                  held_type_in = req_data_byte[7:4];
                  held_channel_in = req_data_byte[3:0];
                  phase_in = PH_DATA1;
               end
            end
            PH_DATA1: begin
               held_first_in = req_data_byte;
               // program change and channel aftertouch carry one data byte
               if (held_type_ff == 4'hC || held_type_ff == 4'hD) begin
                  emit = 1'b1;
                  result_in.kind = KIND_CHANNEL;
                  result_in.abs_time = event_time_ff;
                  result_in.event_type = held_type_ff;
                  result_in.channel = held_channel_ff;
                  result_in.first_data = req_data_byte;
                  phase_in = PH_DELTA;
               end else begin
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA2: begin
               emit = 1'b1;
               result_in.kind = KIND_CHANNEL;
               result_in.abs_time = event_time_ff;
               result_in.event_type = held_type_ff;
               result_in.channel = held_channel_ff;
               result_in.first_data = held_first_ff;
               result_in.second_data = req_data_byte;
               phase_in = PH_DELTA;
            end
            PH_MTYPE: begin
               held_meta_type_in = req_data_byte;
               vlq_value_in = '0;
               vlq_count_in = '0;
               phase_in = PH_MLEN;
            end
            PH_MLEN: begin
               vlq_value_in = vlq_shift;
               vlq_count_in = vlq_count_inc;
               if (vlq_done) begin
                  if ({1'b0, vlq_shift} >= limit_ff) begin
                     emit = 1'b1;
                     result_in.kind = KIND_ERROR;
                     result_in.abs_time = event_time_ff;
                     result_in.error_code = ERR_LENGTH_OVERFLOW;
                     phase_in = PH_ERROR;
                  end else begin
                     meta_total_in = vlq_shift;
                     meta_remaining_in = vlq_shift;
                     vlq_value_in = '0;
                     vlq_count_in = '0;
                     emit = 1'b1;
                     result_in.kind = KIND_META_HEADER;
                     result_in.abs_time = event_time_ff;
                     result_in.meta_type = held_meta_type_ff;
                     result_in.meta_length = vlq_shift;
                     result_in.last_of_meta = (vlq_shift == '0);
                     phase_in = (vlq_shift == '0) ? PH_DELTA : PH_PAYLOAD;
                  end
               end else if (vlq_long) begin
                  emit = 1'b1;
                  result_in.kind = KIND_ERROR;
                  result_in.abs_time = event_time_ff;
                  result_in.error_code = ERR_TOO_LONG;
                  phase_in = PH_ERROR;
               end
            end
            PH_PAYLOAD: begin
               emit = 1'b1;
               meta_remaining_in = remaining_dec;
               result_in.kind = KIND_META_PAYLOAD;
               result_in.abs_time = event_time_ff;
               result_in.meta_type = held_meta_type_ff;
               result_in.meta_length = meta_total_ff;
               result_in.payload_byte = req_data_byte;
               if (remaining_dec == '0) begin
                  result_in.last_of_meta = 1'b1;
                  phase_in = PH_DELTA;
               end
            end
            PH_ERROR: begin
               // bytes are dropped until restart
               phase_in = PH_ERROR;
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= META_LIMIT_RESET;
         phase_ff <= PH_DELTA;
         vlq_value_ff <= '0;
         vlq_count_ff <= '0;
         prev_time_ff <= '0;
         event_time_ff <= '0;
         held_type_ff <= '0;
         held_channel_ff <= '0;
         held_first_ff <= '0;
         held_meta_type_ff <= '0;
         meta_remaining_ff <= '0;
         meta_total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            vlq_value_ff <= vlq_value_in;
            vlq_count_ff <= vlq_count_in;
            prev_time_ff <= prev_time_in;
            event_time_ff <= event_time_in;
            held_type_ff <= held_type_in;
            held_channel_ff <= held_channel_in;
            held_first_ff <= held_first_in;
            held_meta_type_ff <= held_meta_type_in;
            meta_remaining_ff <= meta_remaining_in;
            meta_total_ff <= meta_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = result_ff.kind;
   assign rsp_abs_time = result_ff.abs_time;
   assign rsp_event_type = result_ff.event_type;
   assign rsp_channel = result_ff.channel;
   assign rsp_first_data = result_ff.first_data;
   assign rsp_second_data = result_ff.second_data;
   assign rsp_meta_type = result_ff.meta_type;
   assign rsp_meta_length = result_ff.meta_length;
   assign rsp_payload_byte = result_ff.payload_byte;
   assign rsp_last_of_meta = result_ff.last_of_meta;
   assign rsp_error_code = result_ff.error_code;

   `MTEP_CHECK_NEXT(a_restart_clears, accept && req_restart, (phase_ff == PH_DELTA) && (prev_time_ff == '0) && !rsp_valid_ff, "restart did not clear parser")
   `MTEP_CHECK(a_error_halts, (rsp_valid_ff && (result_ff.kind == KIND_ERROR)) |-> (phase_ff == PH_ERROR), "error result without halted parser")
   `MTEP_CHECK(a_last_leaves_payload, (rsp_valid_ff && (result_ff.kind == KIND_META_PAYLOAD) && result_ff.last_of_meta) |-> (phase_ff != PH_PAYLOAD), "last payload byte left parser in payload")
   `MTEP_CHECK(a_payload_remaining, (phase_ff == PH_PAYLOAD) |-> (meta_remaining_ff != '0), "payload phase with nothing remaining")

endmodule

// ----- test/mtep_tb_pkg.sv -----
// register address, status and event-type codes shared by the parser testbench
// no dependencies
`timescale 1ns / 1ps

package mtep_tb_pkg;

   localparam logic [1:0]  ADDR_META_LENGTH_LIMIT = 2'd0;
   localparam logic [7:0]  STATUS_META = 8'hFF;
   localparam logic [3:0]  TYPE_PROGRAM_CHANGE = 4'hC;
   localparam logic [3:0]  TYPE_CHANNEL_PRESSURE = 4'hD;
   localparam logic [27:0] QUANTITY_MAX = 28'hFFF_FFFF;

endpackage

// ----- test/mtep_event_checker.sv -----
// watches the req, rsp and register channels of the track event parser,
// predicts every result and compares it; depends on mtep_pkg and mtep_tb_pkg
`timescale 1ns / 1ps

module mtep_event_checker
   import mtep_pkg::*;
   import mtep_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [31:0] rsp_abs_time,
   input  logic [3:0]  rsp_event_type,
   input  logic [3:0]  rsp_channel,
   input  logic [7:0]  rsp_first_data,
   input  logic [7:0]  rsp_second_data,
   input  logic [7:0]  rsp_meta_type,
   input  logic [27:0] rsp_meta_length,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_last_of_meta,
   input  logic        rsp_error_code,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          mismatch_count,
   output int          pending_count,
   output int          result_count,
   output int          error_result_count
);

   localparam int MAX_REPORTS = 200;

   typedef enum logic [3:0] {
      ST_DELTA,
      ST_STATUS,
      ST_DATA1,
      ST_DATA2,
      ST_META_TYPE,
      ST_META_LEN,
      ST_PAYLOAD,
      ST_HALTED
   } parse_state_type;

   parse_state_type state;
   logic [27:0]  quantity;
   logic [2:0]   quantity_bytes;
   logic [31:0]  prev_time;
   logic [31:0]  event_time;
   logic [3:0]   held_type;
   logic [3:0]   held_channel;
   logic [7:0]   held_first;
   logic [7:0]   held_meta_type;
   logic [27:0]  meta_left;
   logic [27:0]  meta_len;
   logic [28:0]  length_limit;

   result_type   expected_events[$];
   int           fault_total = 0;
   int           results_seen = 0;
   int           errors_seen = 0;

   task automatic clear_parser();
      state = ST_DELTA;
      quantity = '0;
      quantity_bytes = '0;
      prev_time = '0;
      event_time = '0;
      held_type = '0;
      held_channel = '0;
      held_first = '0;
      held_meta_type = '0;
      meta_left = '0;
      meta_len = '0;
   endtask

   // 7 bits per byte, msb first; too long once a fourth byte still continues
   task automatic take_quantity_byte(input logic [7:0] b, output logic done,
                                     output logic too_long);
      quantity = {quantity[20:0], b[6:0]};
      quantity_bytes = quantity_bytes + 3'd1;
      done = !b[7];
      too_long = b[7] && (quantity_bytes >= 3'd4);
   endtask

   task automatic parse_track_byte(input logic [7:0] b, input logic restart);
      result_type r;
      logic       fire;
      logic       done;
      logic       too_long;
      r = '0;
      fire = 1'b0;
      if (restart) begin
         clear_parser();
      end else begin
         case (state)
            ST_DELTA: begin
               take_quantity_byte(b, done, too_long);
               if (too_long) begin
                  r.kind = KIND_ERROR;
                  r.abs_time = prev_time;
                  r.error_code = ERR_TOO_LONG;
                  state = ST_HALTED;
                  fire = 1'b1;
               end else if (done) begin
                  event_time = prev_time + {4'd0, quantity};
                  prev_time = event_time;
                  quantity = '0;
                  quantity_bytes = '0;
                  state = ST_STATUS;
               end
            end
            ST_STATUS: begin
               if (b == STATUS_META) begin
                  state = ST_META_TYPE;
               end else begin
                  held_type = b[7:4];
                  held_channel = b[3:0];
                  state = ST_DATA1;
               end
            end
            ST_DATA1: begin
               held_first = b;
               if (held_type == TYPE_PROGRAM_CHANGE || held_type == TYPE_CHANNEL_PRESSURE) begin
                  r.kind = KIND_CHANNEL;
                  r.abs_time = event_time;
                  r.event_type = held_type;
                  r.channel = held_channel;
                  r.first_data = held_first;
                  state = ST_DELTA;
                  fire = 1'b1;
               end else begin
                  state = ST_DATA2;
               end
            end
            ST_DATA2: begin
               r.kind = KIND_CHANNEL;
               r.abs_time = event_time;
               r.event_type = held_type;
               r.channel = held_channel;
               r.first_data = held_first;
               r.second_data = b;
               state = ST_DELTA;
               fire = 1'b1;
            end
            ST_META_TYPE: begin
               held_meta_type = b;
               quantity = '0;
               quantity_bytes = '0;
               state = ST_META_LEN;
            end
            ST_META_LEN: begin
               take_quantity_byte(b, done, too_long);
               r.abs_time = event_time;
               if (too_long) begin
                  r.kind = KIND_ERROR;
                  r.error_code = ERR_TOO_LONG;
                  state = ST_HALTED;
                  fire = 1'b1;
               end else if (done && {1'b0, quantity} >= length_limit) begin
                  r.kind = KIND_ERROR;
                  r.error_code = ERR_LENGTH_OVERFLOW;
                  state = ST_HALTED;
                  fire = 1'b1;
               end else if (done) begin
                  meta_len = quantity;
                  meta_left = quantity;
                  quantity = '0;
                  quantity_bytes = '0;
                  r.kind = KIND_META_HEADER;
                  r.meta_type = held_meta_type;
                  r.meta_length = meta_len;
                  r.last_of_meta = (meta_len == '0);
                  state = (meta_len == '0) ? ST_DELTA : ST_PAYLOAD;
                  fire = 1'b1;
               end
            end
            ST_PAYLOAD: begin
               meta_left = meta_left - 28'd1;
               r.kind = KIND_META_PAYLOAD;
               r.abs_time = event_time;
               r.meta_type = held_meta_type;
               r.meta_length = meta_len;
               r.payload_byte = b;
               r.last_of_meta = (meta_left == '0);
               if (meta_left == '0) begin
                  state = ST_DELTA;
               end
               fire = 1'b1;
            end
            default: begin
               // halted after an error until restart
            end
         endcase
      end
      if (fire) begin
         expected_events.insert(expected_events.size(), r);
      end
   endtask

   task automatic report_fault(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      fault_total++;
      if (fault_total <= MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, what, want, got);
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         report_fault(what, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type seen;
      result_type want;
      if (reset) begin
         clear_parser();
         length_limit = META_LIMIT_RESET;
         expected_events.delete();
      end else begin
         // results leave before the byte accepted at this edge can add one
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_kind, rsp_abs_time, rsp_event_type, rsp_channel, rsp_first_data,
                    rsp_second_data, rsp_meta_type, rsp_meta_length, rsp_payload_byte,
                    rsp_last_of_meta, rsp_error_code};
            results_seen++;
            if (rsp_kind == KIND_ERROR) begin
               errors_seen++;
            end
            if (expected_events.size() == 0) begin
               report_fault("unexpected rsp transaction kind", 32'hFFFF_FFFF, 32'(rsp_kind));
            end else begin
               want = expected_events.pop_front();
               check_field("kind", 32'(want.kind), 32'(seen.kind));
               check_field("abs_time", want.abs_time, seen.abs_time);
               check_field("event_type", 32'(want.event_type), 32'(seen.event_type));
               check_field("channel", 32'(want.channel), 32'(seen.channel));
               check_field("first_data", 32'(want.first_data), 32'(seen.first_data));
               check_field("second_data", 32'(want.second_data), 32'(seen.second_data));
               check_field("meta_type", 32'(want.meta_type), 32'(seen.meta_type));
               check_field("meta_length", 32'(want.meta_length), 32'(seen.meta_length));
               check_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
               check_field("last_of_meta", 32'(want.last_of_meta), 32'(seen.last_of_meta));
               check_field("error_code", 32'(want.error_code), 32'(seen.error_code));
            end
         end
         if (req_valid && !req_stall) begin
            parse_track_byte(req_data_byte, req_restart);
         end
         if (psel && penable && pready && paddr == ADDR_META_LENGTH_LIMIT) begin
            if (pwrite) begin
               length_limit = pwdata[28:0];
            end else begin
               check_field("prdata", {3'd0, length_limit}, prdata);
            end
         end
      end
      pending_count <= expected_events.size();
      mismatch_count <= fault_total;
      result_count <= results_seen;
      error_result_count <= errors_seen;
   end

endmodule

// ----- test/tb_top.sv -----
// top of the track event parser testbench: clock, reset, byte stream,
// register writes and verdict; depends on mtep_pkg, mtep_tb_pkg and mtep_event_checker
`timescale 1ns / 1ps

module tb_top;
   import mtep_pkg::*;
   import mtep_tb_pkg::*;

   localparam int PHASE_BYTES = 190;
   localparam int PHASE_TOTAL = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_abs_time;
   logic [3:0]  rsp_event_type;
   logic [3:0]  rsp_channel;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   logic [7:0]  rsp_meta_type;
   logic [27:0] rsp_meta_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_of_meta;
   logic        rsp_error_code;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int          mismatch_count;
   int          pending_count;
   int          result_count;
   int          error_result_count;

   logic        idle_off = 1'b0;
   int          stall_run = 0;
   int          quiet_cycles = 0;
   int          bytes_sent = 0;
   int          settings_done = 0;
   logic [28:0] current_limit = META_LIMIT_RESET;
   // bit 8 marks a restart transaction
   logic [8:0]  track_bytes[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   midi_track_event_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_abs_time     (rsp_abs_time),
      .rsp_event_type   (rsp_event_type),
      .rsp_channel      (rsp_channel),
      .rsp_first_data   (rsp_first_data),
      .rsp_second_data  (rsp_second_data),
      .rsp_meta_type    (rsp_meta_type),
      .rsp_meta_length  (rsp_meta_length),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last_of_meta (rsp_last_of_meta),
      .rsp_error_code   (rsp_error_code),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   mtep_event_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_abs_time       (rsp_abs_time),
      .rsp_event_type     (rsp_event_type),
      .rsp_channel        (rsp_channel),
      .rsp_first_data     (rsp_first_data),
      .rsp_second_data    (rsp_second_data),
      .rsp_meta_type      (rsp_meta_type),
      .rsp_meta_length    (rsp_meta_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_meta   (rsp_last_of_meta),
      .rsp_error_code     (rsp_error_code),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .result_count       (result_count),
      .error_result_count (error_result_count)
   );

   // receiver back-pressure: mostly short runs, a few long ones
   always @(posedge clock) begin
      if (reset || idle_off) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
      end else begin : pick_stall
         int roll;
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(0, 4);
         end else if (roll < 95) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [27:0] pick_delta();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 28'($urandom_range(0, 127));
      if (roll < 80) return 28'($urandom_range(0, 16383));
      if (roll < 95) return 28'($urandom);
      return QUANTITY_MAX;
   endfunction

   function automatic logic [27:0] pick_meta_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 28'($urandom_range(0, 4));
      if (roll < 88) return 28'($urandom_range(5, 12));
      if (roll < 96) return 28'($urandom);
      return QUANTITY_MAX;
   endfunction

   task automatic queue_byte(input logic [7:0] b);
      track_bytes.insert(track_bytes.size(), {1'b0, b});
   endtask

   task automatic queue_restart();
      track_bytes.insert(track_bytes.size(), {1'b1, 8'($urandom)});
   endtask

   // shortest encoding most of the time, sometimes padded with leading 0x80
   task automatic queue_quantity(input logic [27:0] value);
      int fewest;
      int count;
      fewest = (value < 28'h80) ? 1 : (value < 28'h4000) ? 2 : (value < 28'h20_0000) ? 3 : 4;
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(fewest, 4) : fewest;
      for (int i = count - 1; i >= 0; i--) begin
         queue_byte({i != 0, 7'(value >> (7 * i))});
      end
   endtask

   task automatic queue_too_long();
      repeat (4) queue_byte({1'b1, 7'($urandom)});
   endtask

   task automatic queue_noise_and_restart();
      repeat ($urandom_range(0, 3)) queue_byte(8'($urandom));
      queue_restart();
   endtask

   task automatic queue_random_event();
      int          roll;
      logic [7:0]  status;
      logic [27:0] length;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         queue_quantity(pick_delta());
         status = 8'($urandom_range(0, 254));
         queue_byte(status);
         queue_byte(8'($urandom));
         if (status[7:4] != TYPE_PROGRAM_CHANGE && status[7:4] != TYPE_CHANNEL_PRESSURE) begin
            queue_byte(8'($urandom));
         end
      end else if (roll < 80) begin
         queue_quantity(pick_delta());
         queue_byte(STATUS_META);
         queue_byte(8'($urandom));
         length = pick_meta_length();
         queue_quantity(length);
         if ({1'b0, length} >= current_limit) begin
            queue_noise_and_restart();
         end else if (length <= 28'd12) begin
            repeat (length) queue_byte(8'($urandom));
         end else begin
            // huge payload: stream a few bytes, then abandon the track
            repeat ($urandom_range(1, 5)) queue_byte(8'($urandom));
            queue_restart();
         end
      end else if (roll < 86) begin
         queue_too_long();
         queue_noise_and_restart();
      end else if (roll < 91) begin
         queue_quantity(pick_delta());
         queue_byte(STATUS_META);
         queue_byte(8'($urandom));
         queue_too_long();
         queue_noise_and_restart();
      end else if (roll < 95) begin
         // event cut short by a restart
         queue_quantity(pick_delta());
         queue_byte(8'($urandom));
         if ($urandom_range(0, 1) == 1) begin
            queue_byte(8'($urandom));
         end
         queue_restart();
      end else begin
         repeat ($urandom_range(1, 8)) queue_byte(8'($urandom));
         queue_restart();
      end
   endtask

   task automatic send_track(inout int phase_bytes);
      logic [8:0] item;
      int         gap;
      while (track_bytes.size() != 0) begin
         item = track_bytes.pop_front();
         req_valid <= 1'b1;
         req_data_byte <= item[7:0];
         req_restart <= item[8];
         @(posedge clock);
         while (req_stall) @(posedge clock);
         bytes_sent++;
         phase_bytes++;
         gap = idle_off ? 0 : pick_gap();
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // write the limit, then read it back
   task automatic program_limit(input logic [28:0] value);
      current_limit = value;
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= ADDR_META_LENGTH_LIMIT;
      pwdata <= {3'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      settings_done++;
   endtask

   task automatic wait_for_drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [28:0] limit_plan[$];
      int          phase_bytes;
      limit_plan = '{META_LIMIT_RESET, 29'd1, 29'($urandom_range(2, 6)),
                     29'($urandom_range(1, 268435456)), 29'd4, META_LIMIT_RESET};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < PHASE_TOTAL; p++) begin
         program_limit(limit_plan[p]);
         // one whole phase runs with neither side idling
         idle_off <= (p == 2);
         phase_bytes = 0;
         if (p == 0) begin
            track_bytes = '{
               // status below 0x80 taken as a two-byte event, data extremes
               9'h000, 9'h07A, 9'h000, 9'h0FF,
               // longest delta, program change on channel 15
               9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h0CF, 9'h0FF,
               // zero-length meta, header only
               9'h000, 9'h0FF, 9'h02F, 9'h000,
               // two-byte delta, meta with two payload bytes
               9'h081, 9'h000, 9'h0FF, 9'h001, 9'h002, 9'h041, 9'h042,
               // status in the system range read as a channel event
               9'h000, 9'h0F3, 9'h080, 9'h07F,
               // delta too long, one ignored byte, restart
               9'h080, 9'h080, 9'h080, 9'h080, 9'h055, 9'h1AA
            };
            send_track(phase_bytes);
         end
         while (phase_bytes < PHASE_BYTES) begin
            queue_random_event();
            send_track(phase_bytes);
         end
         req_valid <= 1'b0;
         wait_for_drain();
      end
      $display("covered %0d track bytes under %0d limit settings, %0d results checked",
               bytes_sent, settings_done, result_count);
      $display("%0d of those results were error reports", error_result_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mtep_pkg.sv
rtl/midi_track_event_parser.sv
test/mtep_tb_pkg.sv
test/mtep_event_checker.sv
test/tb_top.sv
